FILE: rtl/cwmf_pkg.sv
package cwmf_pkg;

  localparam int PIX_W      = 8;
  localparam int IW_W       = 11;
  localparam int IH_W       = 12;
  localparam int WS_W       = 3;
  localparam int OFF_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int FIFO_DEPTH = 8;

  typedef logic [PIX_W-1:0]      pixel_t;
  typedef logic [IH_W-1:0]       row_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_WINDOW_SIZE  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    pixel_t median;
    logic   last;
  } result_t;

endpackage

FILE: rtl/cwmf_if.sv
interface cwmf_in_if;
  import cwmf_pkg::*;
  logic   valid;
  logic   ready;
  logic   mode;
  pixel_t pixel_value;
  modport source (output valid, output mode, output pixel_value, input ready);
  modport sink (input valid, input mode, input pixel_value, output ready);
endinterface

interface cwmf_out_if;
  import cwmf_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t median_value;
  logic   last_in_frame;
  modport source (output valid, output median_value, output last_in_frame, input ready);
  modport sink (input valid, input median_value, input last_in_frame, output ready);
endinterface

interface cwmf_cfg_if;
  import cwmf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  cfg_data_t            data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/clipped_window_median_filter.sv
// Clipped square-window median filter for 8-bit raster frames.
// in_if: one request per pixel (mode 0) or drain tick (mode 1), raster order.
// out_if: one median per output pixel, raster order, last_in_frame on the last.
// cfg_if: register writes (0 width, 1 height, 2 window side), always ready;
// each write to one of these restarts the frame. Write only while the block is idle.
// Throughput: one request per cycle while the output queue has room, except that
// the first output of each row holds the input while the line store, a single
// column-wide memory with one read port, is read for the leading columns.
// Path: the request that releases a result starts a line store read; the result
// is then registered through the column window, window gather and rank network
// into the output queue. A result waits until off rows and columns of lookahead arrive.
// Reset (synchronous, rst_n low): width 1024, height 1024, window 3, frame
// positions cleared; the line store is not cleared, every entry used is
// written earlier in the frame. No clearing pass.
// Stall: results queue in an 8-entry output queue; input ready drops once 8
// results are outstanding, so nothing is lost when the receiver stalls.
module clipped_window_median_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  cwmf_in_if.sink     in_if,
  cwmf_out_if.source  out_if,
  cwmf_cfg_if.sink    cfg_if
);
  import cwmf_pkg::*;

  localparam int MO = MAX_WINDOW / 2;
  localparam int WN = 2 * MO + 1;
  localparam int NW = WN * WN;
  localparam int SR = MAX_WINDOW + 1;
  localparam int LW = (SR > 1) ? $clog2(SR) : 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(NW + 1);
  localparam int FW = $clog2(FIFO_DEPTH);
  localparam int PW = $clog2(FIFO_DEPTH + 1);
  localparam int DW = SR * PIX_W;

  typedef logic [CW-1:0] col_t;
  typedef logic [LW-1:0] lane_t;

  typedef struct packed {
    row_t  row;
    col_t  col;
    lane_t lane;
    logic  last;
  } job_t;

  function automatic lane_t lane_of(lane_t base, int d);
    int l;
    l = int'(base) + d;
    if (l < 0) l = l + SR;
    else if (l >= SR) l = l - SR;
    return LW'(l);
  endfunction

  function automatic logic in_span(int pos, int d, int lim_m1, int off);
    return (d <= off) && (-d <= off) && (pos + d >= 0) && (pos + d <= lim_m1);
  endfunction

  // configuration
  logic [IW_W-1:0] iw_r;
  logic [IH_W-1:0] ih_r;
  logic [WS_W-1:0] ws_r;
  logic            cfg_acc;
  logic            cfg_hit;

  col_t            wm1;
  row_t            hm1;
  logic [OFF_W-1:0] off;
  logic            odd;

  assign cfg_if.ready = 1'b1;
  assign cfg_acc = cfg_if.valid && cfg_if.ready;

  always_comb begin
    unique case (cfg_if.index)
      CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_WINDOW_SIZE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= IW_W'(1024);
      ih_r <= IH_W'(1024);
      ws_r <= WS_W'(3);
    end else if (cfg_acc) begin
      unique case (cfg_if.index)
        CFG_IMAGE_WIDTH:  iw_r <= cfg_if.data[IW_W-1:0];
        CFG_IMAGE_HEIGHT: ih_r <= cfg_if.data[IH_W-1:0];
        CFG_WINDOW_SIZE:  ws_r <= cfg_if.data[WS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (iw_r == '0) wm1 = '0;
    else if (int'(iw_r) > MAX_WIDTH) wm1 = CW'(MAX_WIDTH - 1);
    else wm1 = CW'(iw_r - IW_W'(1));
    hm1 = (ih_r == '0) ? '0 : ih_r - IH_W'(1);
    off = ws_r[WS_W-1:1];
    odd = ws_r[0];
  end

  // frame positions
  row_t  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  col_t  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  lane_t in_lane_r, in_lane_nxt, out_lane_r, out_lane_nxt;
  logic  in_done_r, in_done_nxt;

  logic              in_acc, pix, emit, last, ready_out;
  logic [IH_W:0]     nr;
  logic [CW:0]       nc;
  logic [PW-1:0]     pend_r;
  logic              s1_v_r;
  logic [OFF_W-1:0]  s1_cnt_r;

  assign in_if.ready = (pend_r < PW'(FIFO_DEPTH)) && !(s1_v_r && s1_cnt_r != '0);
  assign in_acc = in_if.valid && in_if.ready;
  assign pix = in_acc && odd && !in_if.mode && !in_done_r;

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    in_lane_nxt = in_lane_r;
    in_done_nxt = in_done_r;
    if (pix) begin
      if (in_col_r == wm1) begin
        in_col_nxt  = '0;
        in_row_nxt  = in_row_r + IH_W'(1);
        in_lane_nxt = (int'(in_lane_r) == SR - 1) ? '0 : in_lane_r + LW'(1);
        if (in_row_r >= hm1) in_done_nxt = 1'b1;
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
    nr = {1'b0, out_row_r} + (IH_W + 1)'(off);
    if (nr > {1'b0, hm1}) nr = {1'b0, hm1};
    nc = {1'b0, out_col_r} + (CW + 1)'(off);
    if (nc > {1'b0, wm1}) nc = {1'b0, wm1};
    ready_out = in_done_nxt || ({1'b0, in_row_nxt} > nr) ||
                (({1'b0, in_row_nxt} == nr) && ({1'b0, in_col_nxt} > nc));
    emit = in_acc && odd && ready_out;
    last = (out_row_r == hm1) && (out_col_r == wm1);
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_lane_nxt = out_lane_r;
    if (emit) begin
      if (last) begin
        in_row_nxt   = '0;
        in_col_nxt   = '0;
        in_lane_nxt  = '0;
        in_done_nxt  = 1'b0;
        out_row_nxt  = '0;
        out_col_nxt  = '0;
        out_lane_nxt = '0;
      end else if (out_col_r == wm1) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + IH_W'(1);
        out_lane_nxt = (int'(out_lane_r) == SR - 1) ? '0 : out_lane_r + LW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_acc && cfg_hit)) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_lane_r  <= '0;
      in_done_r  <= 1'b0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_lane_r <= '0;
    end else begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_lane_r  <= in_lane_nxt;
      in_done_r  <= in_done_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_lane_r <= out_lane_nxt;
    end
  end

  // line store: one word per column, one byte lane per stored row
  logic [DW-1:0] line_mem [MAX_WIDTH];
  logic [DW-1:0] mem_q_r;
  col_t          s1_col_r;
  job_t          s1_job_r;

  always_ff @(posedge clk) begin
    if (pix) line_mem[in_col_r][PIX_W*in_lane_r +: PIX_W] <= in_if.pixel_value;
    if (s1_v_r) mem_q_r <= line_mem[s1_col_r];
  end

  // read sequencer: leading columns at row start, else the newest column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_cnt_r <= '0;
    end else if (emit) begin
      s1_v_r   <= 1'b1;
      s1_cnt_r <= (out_col_r == '0) ? off : '0;
    end else if (s1_v_r && s1_cnt_r != '0) begin
      s1_cnt_r <= s1_cnt_r - OFF_W'(1);
    end else begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_job_r <= '{row: out_row_r, col: out_col_r, lane: out_lane_r, last: last};
      s1_col_r <= (out_col_r == '0) ? '0 : out_col_r + CW'(off);
    end else if (s1_v_r && s1_cnt_r != '0) begin
      s1_col_r <= s1_col_r + CW'(1);
    end
  end

  // column window
  logic          s2_v_r, s2_last_r;
  job_t          s2_job_r;
  logic [DW-1:0] colw_r [WN];
  logic          s3_v_r;
  job_t          s3_job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_last_r <= (s1_cnt_r == '0);
    s2_job_r  <= s1_job_r;
    s3_job_r  <= s2_job_r;
    if (s2_v_r) begin
      for (int j = 0; j < WN; j++) begin
        if (j == MO + int'(off)) colw_r[j] <= mem_q_r;
        else if (j < WN - 1) colw_r[j] <= colw_r[j+1];
      end
    end
  end

  // window gather with clipping
  pixel_t          win_v_nxt [NW];
  logic [NW-1:0]   win_m_nxt;
  pixel_t          win_v_r [NW];
  logic [NW-1:0]   win_m_r;
  logic [RW-1:0]   half_r;
  logic            s4_v_r, s4_last_r;

  always_comb begin
    for (int i = 0; i < WN; i++) begin
      for (int j = 0; j < WN; j++) begin
        win_m_nxt[i*WN+j] =
          in_span(int'(s3_job_r.row), i - MO, int'(hm1), int'(off)) &&
          in_span(int'(s3_job_r.col), j - MO, int'(wm1), int'(off));
        win_v_nxt[i*WN+j] = win_m_nxt[i*WN+j] ?
          colw_r[j][PIX_W*lane_of(s3_job_r.lane, i - MO) +: PIX_W] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_v_r    <= rst_n && s3_v_r;
    s4_last_r <= s3_job_r.last;
    win_v_r   <= win_v_nxt;
    win_m_r   <= win_m_nxt;
    half_r    <= RW'($countones(win_m_nxt) >> 1);
  end

  // rank network
  logic [NW-1:0] lt_r [NW];
  pixel_t        v5_r [NW];
  logic [NW-1:0] m5_r;
  logic [RW-1:0] half5_r;
  logic          s5_v_r, s5_last_r;

  always_ff @(posedge clk) begin
    s5_v_r    <= rst_n && s4_v_r;
    s5_last_r <= s4_last_r;
    v5_r      <= win_v_r;
    m5_r      <= win_m_r;
    half5_r   <= half_r;
    for (int i = 0; i < NW; i++) begin
      for (int j = 0; j < NW; j++) begin
        lt_r[i][j] <= win_m_r[j] &&
                      ((win_v_r[j] < win_v_r[i]) || ((win_v_r[j] == win_v_r[i]) && (j < i)));
      end
    end
  end

  logic [NW-1:0] hit6_r;
  pixel_t        v6_r [NW];
  logic          s6_v_r, s6_last_r;
  pixel_t        sel;

  always_ff @(posedge clk) begin
    s6_v_r    <= rst_n && s5_v_r;
    s6_last_r <= s5_last_r;
    v6_r      <= v5_r;
    for (int i = 0; i < NW; i++) begin
      hit6_r[i] <= m5_r[i] && (RW'($countones(lt_r[i])) == half5_r);
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < NW; i++) begin
      sel = sel | (hit6_r[i] ? v6_r[i] : '0);
    end
  end

  // output queue
  result_t       fifo_mem [FIFO_DEPTH];
  logic [FW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW-1:0] fifo_cnt_r;
  logic          pop;

  assign out_if.valid         = (fifo_cnt_r != '0);
  assign out_if.median_value  = fifo_mem[rd_ptr_r].median;
  assign out_if.last_in_frame = fifo_mem[rd_ptr_r].last;
  assign pop = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (s6_v_r) fifo_mem[wr_ptr_r] <= '{median: sel, last: s6_last_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      pend_r     <= '0;
    end else begin
      if (s6_v_r) wr_ptr_r <= wr_ptr_r + FW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + FW'(1);
      fifo_cnt_r <= fifo_cnt_r + PW'(s6_v_r) - PW'(pop);
      pend_r     <= pend_r + PW'(emit) - PW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PW'(FIFO_DEPTH))
    else $error("outstanding results exceed queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s6_v_r |-> (fifo_cnt_r != PW'(FIFO_DEPTH)) || pop)
    else $error("output queue overflow");

  a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
    s6_v_r |-> $onehot(hit6_r))
    else $error("median select not one-hot");

  a_centre_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> win_m_r[NW/2])
    else $error("centre pixel masked out");

  a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> pend_r >= fifo_cnt_r)
    else $error("queued results not accounted");
`endif

endmodule

FILE: sim/cwmf_checker.sv
module cwmf_checker (
  input  logic  clk,
  input  logic  rst_n,
  cwmf_in_if    in_if,
  cwmf_out_if   out_if,
  cwmf_cfg_if   cfg_if,
  output int    errors,
  output int    pending
);
  import cwmf_pkg::*;

  localparam int STORE_ROWS = 8;
  localparam int MAXW       = 1024;

  pixel_t            line_mem [STORE_ROWS][MAXW];
  logic [IW_W-1:0]   img_w;
  logic [IH_W-1:0]   img_h;
  logic [WS_W-1:0]   win;
  int                in_r, in_c, out_r, out_c;
  bit                frame_in;
  result_t           medians_due [$];

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void restart();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0; frame_in = 0;
  endfunction

  function automatic pixel_t clipped_median(int off, int w, int h);
    pixel_t vals [$];
    pixel_t t;
    int r0, c0, r1, c1, j;
    r0 = out_r >= off ? out_r - off : 0;
    c0 = out_c >= off ? out_c - off : 0;
    r1 = (out_r + off > h - 1) ? h - 1 : out_r + off;
    c1 = (out_c + off > w - 1) ? w - 1 : out_c + off;
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++) vals = {vals, line_mem[r % STORE_ROWS][c % MAXW]};
    for (int i = 1; i < vals.size(); i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > t) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = t;
    end
    return vals[vals.size() / 2];
  endfunction

  function automatic void take_request(logic mode, pixel_t pix);
    int w, h, off, nr, nc;
    bit rdy, last;
    result_t res;
    w = img_w == 0 ? 1 : (img_w > MAXW ? MAXW : int'(img_w));
    h = img_h == 0 ? 1 : int'(img_h);
    if (!win[0]) return;
    off = (int'(win) - 1) / 2;
    if (!mode && !frame_in) begin
      line_mem[in_r % STORE_ROWS][in_c % MAXW] = pix;
      if (in_c + 1 >= w) begin
        in_c = 0;
        in_r++;
        if (in_r >= h) frame_in = 1;
      end else in_c++;
    end
    nr = out_r + off > h - 1 ? h - 1 : out_r + off;
    nc = out_c + off > w - 1 ? w - 1 : out_c + off;
    rdy = frame_in || in_r > nr || (in_r == nr && in_c > nc);
    if (!rdy) return;
    last = (out_r + 1 >= h) && (out_c + 1 >= w);
    res.median = clipped_median(off, w, h);
    res.last = last;
    medians_due = {medians_due, res};
    if (last) restart();
    else if (out_c + 1 >= w) begin
      out_c = 0;
      out_r++;
    end else out_c++;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      img_w = 1024;
      img_h = 1024;
      win = 3;
      restart();
      medians_due.delete();
      errors = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_t'(cfg_if.index))
          CFG_IMAGE_WIDTH:  begin img_w = cfg_if.data[IW_W-1:0]; restart(); end
          CFG_IMAGE_HEIGHT: begin img_h = cfg_if.data[IH_W-1:0]; restart(); end
          CFG_WINDOW_SIZE:  begin win = cfg_if.data[WS_W-1:0]; restart(); end
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) take_request(in_if.mode, in_if.pixel_value);
      if (out_if.valid && out_if.ready) begin
        if (medians_due.size() == 0) begin
          report("unexpected median_value", out_if.median_value, -1);
        end else begin
          want = medians_due.pop_front();
          if (out_if.median_value !== want.median)
            report("median_value", out_if.median_value, want.median);
          if (out_if.last_in_frame !== want.last)
            report("last_in_frame", out_if.last_in_frame, want.last);
        end
      end
    end
    pending = medians_due.size();
  end
endmodule

FILE: sim/clipped_window_median_filter_tb.sv
module clipped_window_median_filter_tb;
  import cwmf_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   errors, pending, medians_seen, pixels_sent;
  bit   calm;

  cwmf_in_if  in_if ();
  cwmf_out_if out_if ();
  cwmf_cfg_if cfg_if ();

  clipped_window_median_filter dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  cwmf_checker chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (calm || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk) if (out_if.valid && out_if.ready) medians_seen++;

  int stall;
  always @(negedge clk) begin
    if (!rst_n) out_if.ready <= 0;
    else if (stall > 0) begin
      out_if.ready <= 0;
      stall--;
    end else begin
      out_if.ready <= 1;
      stall = gap_len();
    end
  end

  task automatic send_req(logic m, pixel_t p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_if.valid <= 1;
    in_if.mode <= m;
    in_if.pixel_value <= p;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    in_if.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 0;
  endtask

  function automatic pixel_t rand_pixel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic run_phase(int w_raw, int h_raw, int ws, int frames);
    int w, h, target;
    write_reg(CFG_IMAGE_WIDTH, cfg_data_t'(w_raw));
    write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'(h_raw));
    write_reg(CFG_WINDOW_SIZE, cfg_data_t'(ws));
    calm = ($urandom_range(4) == 0);
    w = w_raw == 0 ? 1 : (w_raw > 1024 ? 1024 : w_raw);
    h = h_raw == 0 ? 1 : h_raw;
    repeat (frames) begin
      target = medians_seen + w * h;
      for (int i = 0; i < w * h; i++) begin
        if ($urandom_range(9) == 0) send_req(1, pixel_t'($urandom));
        send_req(0, rand_pixel());
        pixels_sent++;
      end
      if (ws % 2 == 1) begin
        while (medians_seen < target)
          send_req((target - medians_seen > 24) ? logic'($urandom_range(1)) : 1'b1,
                   pixel_t'($urandom));
      end else begin
        repeat ($urandom_range(3)) send_req(1, pixel_t'($urandom));
      end
    end
  endtask

  initial begin
    in_if.valid = 0;
    in_if.mode = 0;
    in_if.pixel_value = 0;
    cfg_if.valid = 0;
    cfg_if.index = CFG_IMAGE_WIDTH;
    cfg_if.data = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    run_phase(1, 1, 1, 2);
    run_phase(3, 2, 3, 1);
    run_phase(0, 0, 7, 1);
    run_phase(4, 3, 2, 1);
    run_phase(2047, 1, 3, 1);
    run_phase(1, 40, 7, 1);
    run_phase(9, 7, 5, 1);
    run_phase(5, 4, 0, 1);
    run_phase(6, 5, 6, 1);
    while (pixels_sent < 1300) begin
      run_phase($urandom_range(16, 1), $urandom_range(10, 1),
                ($urandom_range(7) == 0) ? 2 * $urandom_range(3) : 2 * $urandom_range(3) + 1,
                $urandom_range(3, 1));
    end
    in_if.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
